FILE: hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the seven-segment test
// pattern driver. No dependencies.
package ssd_pkg;

  localparam int BTN_COUNT = 4;
  localparam int WORD_W    = 16;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARADE   = 2'd2;

  localparam logic [4:0] DEBOUNCE_RST = 5'd30;
  localparam logic [9:0] BEAT_RST     = 10'd500;
  localparam logic [9:0] PARADE_RST   = 10'd700;

  // Display modes
  localparam logic [1:0] MODE_COUNTER = 2'd0;
  localparam logic [1:0] MODE_PARADE  = 2'd1;
  localparam logic [1:0] MODE_ALL_ON  = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  // Speed selects
  localparam logic [1:0] SPEED_10MS  = 2'd0;
  localparam logic [1:0] SPEED_100MS = 2'd1;
  localparam logic [1:0] SPEED_1MS   = 2'd2;

  localparam logic [9:0] ELAPSED_MAX     = 10'd1023;
  localparam logic [4:0] BTN_ELAPSED_MAX = 5'd31;
  localparam logic [4:0] GLYPH_LAST      = 5'd16;
  localparam logic [4:0] GLYPH_EIGHT     = 5'd8;
  localparam logic [4:0] GLYPH_BLANK     = 5'd10;

  // Segment bit positions, active high
  localparam logic [15:0] SG_A  = 16'h0001 << 4;
  localparam logic [15:0] SG_B  = 16'h0001 << 12;
  localparam logic [15:0] SG_C  = 16'h0001 << 7;
  localparam logic [15:0] SG_D  = 16'h0001 << 3;
  localparam logic [15:0] SG_E  = 16'h0001 << 1;
  localparam logic [15:0] SG_F  = 16'h0001 << 6;
  localparam logic [15:0] SG_G  = 16'h0001 << 11;
  localparam logic [15:0] SG_DP = 16'h0001 << 5;

  // Digit selects, active low
  localparam logic [15:0] SEL_0 = 16'h0001 << 2;
  localparam logic [15:0] SEL_1 = 16'h0001 << 9;
  localparam logic [15:0] SEL_2 = 16'h0001 << 10;
  localparam logic [15:0] SEL_3 = 16'h0001 << 13;
  localparam logic [15:0] SEL_MASK = SEL_0 | SEL_1 | SEL_2 | SEL_3;

  typedef struct packed {
    logic mode;
    logic speed;
    logic blank;
    logic beat;
  } press_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  pos;
    logic        blank_zeros;
    logic        beat_enable;
    logic        beat_phase;
    logic [15:0] count_bcd;
    logic [4:0]  parade_index;
  } disp_state_t;

  function automatic logic [15:0] glyph_seg(input logic [4:0] idx);
    logic [15:0] seg;
    unique case (idx)
      5'd0:    seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      5'd1:    seg = SG_B | SG_C;
      5'd2:    seg = SG_A | SG_B | SG_G | SG_E | SG_D;
      5'd3:    seg = SG_A | SG_B | SG_G | SG_C | SG_D;
      5'd4:    seg = SG_F | SG_G | SG_B | SG_C;
      5'd5:    seg = SG_A | SG_F | SG_G | SG_C | SG_D;
      5'd6:    seg = SG_A | SG_F | SG_G | SG_E | SG_D | SG_C;
      5'd7:    seg = SG_A | SG_B | SG_C;
      5'd8:    seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G;
      5'd9:    seg = SG_A | SG_B | SG_C | SG_D | SG_F | SG_G;
      5'd11:   seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      5'd12:   seg = SG_E | SG_G | SG_C;
      5'd13:   seg = SG_A | SG_F | SG_G | SG_E;
      5'd14:   seg = SG_A | SG_F | SG_G | SG_E | SG_D;
      5'd15:   seg = SG_E | SG_G;
      5'd16:   seg = SG_D;
      default: seg = '0;
    endcase
    return seg;
  endfunction

  // Packed BCD increment; a nibble of nine or above rolls to zero and carries.
  function automatic logic [15:0] bcd_inc(input logic [15:0] v);
    logic [15:0] r;
    logic        carry;
    r     = v;
    carry = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (carry) begin
        if (v[4*k +: 4] < 4'd9) begin
          r[4*k +: 4] = v[4*k +: 4] + 4'd1;
          carry       = 1'b0;
        end else begin
          r[4*k +: 4] = 4'd0;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ssd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the display words.
// Depends on ssd_pkg.
interface ssd_in_if;
  import ssd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 ms_tick;
  logic [BTN_COUNT-1:0] button_levels;

  modport source (output valid, output ms_tick, output button_levels, input ready);
  modport sink   (input valid, input ms_tick, input button_levels, output ready);
endinterface

interface ssd_out_if;
  import ssd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] display_word;

  modport source (output valid, output display_word, input ready);
  modport sink   (input valid, input display_word, output ready);
endinterface

FILE: hw/rtl/ssd_debounce.sv
`timescale 1ns / 1ps
// Four-button debouncer with saturating millisecond counters; flags accepted presses.
// Depends on ssd_pkg.
module ssd_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          ms_tick,
  input  logic [ssd_pkg::BTN_COUNT-1:0] levels,
  input  logic [4:0]                    settle_ms,
  output ssd_pkg::press_t               press
);
  import ssd_pkg::*;

  logic [BTN_COUNT-1:0] stable_r, stable_nxt;
  logic [4:0]           elapsed_r   [BTN_COUNT];
  logic [4:0]           elapsed_nxt [BTN_COUNT];
  logic [BTN_COUNT-1:0] pressed;

  always_comb begin
    logic [4:0] e;
    for (int i = 0; i < BTN_COUNT; i++) begin
      e = elapsed_r[i];
      if (ms_tick && e != BTN_ELAPSED_MAX) e = e + 5'd1;
      stable_nxt[i] = stable_r[i];
      pressed[i]    = 1'b0;
      if (levels[i] == stable_r[i]) begin
        e = '0;
      end else if (e >= settle_ms) begin
        stable_nxt[i] = levels[i];
        e             = '0;
        pressed[i]    = ~levels[i];
      end
      elapsed_nxt[i] = e;
    end
  end

  assign press.mode  = en & pressed[0];
  assign press.speed = en & pressed[1];
  assign press.blank = en & pressed[2];
  assign press.beat  = en & pressed[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '1;
      for (int i = 0; i < BTN_COUNT; i++) elapsed_r[i] <= '0;
    end else if (en) begin
      stable_r <= stable_nxt;
      for (int i = 0; i < BTN_COUNT; i++) elapsed_r[i] <= elapsed_nxt[i];
    end
  end

endmodule

FILE: hw/rtl/ssd_glyph.sv
`timescale 1ns / 1ps
// Display word former: glyph choice, leading-zero blanking, points and digit selects.
// Depends on ssd_pkg.
module ssd_glyph (
  input  ssd_pkg::disp_state_t         st,
  output logic [ssd_pkg::WORD_W-1:0]   word
);
  import ssd_pkg::*;

  logic [3:0]  nib;
  logic        lead_zero;
  logic [4:0]  idx;
  logic [15:0] sel;
  logic [15:0] seg;

  always_comb begin
    nib = st.count_bcd[4*(3 - st.pos) +: 4];
    unique case (st.pos)
      2'd0:    lead_zero = st.count_bcd[15:12] == 4'd0;
      2'd1:    lead_zero = st.count_bcd[15:8] == 8'd0;
      2'd2:    lead_zero = st.count_bcd[15:4] == 12'd0;
      default: lead_zero = 1'b0;
    endcase

    if (st.mode == MODE_ALL_ON) begin
      idx = GLYPH_EIGHT;
    end else if (st.mode == MODE_PARADE) begin
      idx = (st.parade_index <= GLYPH_LAST) ? st.parade_index : GLYPH_BLANK;
    end else if (st.blank_zeros && lead_zero) begin
      idx = GLYPH_BLANK;
    end else begin
      idx = {1'b0, nib};
    end

    unique case (st.pos)
      2'd0:    sel = SEL_0;
      2'd1:    sel = SEL_1;
      2'd2:    sel = SEL_2;
      default: sel = SEL_3;
    endcase

    seg = glyph_seg(idx);
    if (st.mode == MODE_ALL_ON) begin
      seg = seg | SG_DP;
    end else if (st.beat_phase && st.beat_enable && st.pos == 2'd0) begin
      seg = seg | SG_DP;
    end
    word = (seg | SEL_MASK) & ~sel;
  end

endmodule

FILE: hw/rtl/seven_segment_test_pattern_mux.sv
`timescale 1ns / 1ps
// Top level of the seven-segment test pattern driver.
// Depends on ssd_pkg, ssd_if, ssd_debounce and ssd_glyph.

// One item goes in per display refresh pass and one display word comes out
// for it. The block sustains one item per clock cycle while the output is not
// stalled; an accepted item sits in the input register, and when it advances
// the single-pass state update runs and its word is loaded into the result
// register. The word shows the digit at the current position, built from the
// state before the item's own timer, button and step updates take effect. The
// user must write the three timing registers through the cfg_ port only while no
// item is in flight; the block itself does not enforce this. They come out of
// reset as 30 ms debounce, 500 ms heartbeat half-period and 700 ms parade step.
// A stalled output holds its word and holds the item behind it in the input
// register.
module seven_segment_test_pattern_mux (
  input  logic                          clk,
  input  logic                          rst_n,
  ssd_in_if.sink                        in_ch,
  ssd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssd_pkg::CFG_W-1:0]     cfg_data
);
  import ssd_pkg::*;

  // Configuration registers
  logic [4:0] settle_ms_r;
  logic [9:0] beat_half_ms_r;
  logic [9:0] parade_step_ms_r;

  // Input register stage
  logic                 s1_valid_r;
  logic                 s1_tick_r;
  logic [BTN_COUNT-1:0] s1_levels_r;
  logic                 s1_adv;

  // Result register stage
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [WORD_W-1:0] word;

  // Block state
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  speed_r, speed_nxt;
  logic        blank_r, blank_nxt;
  logic        beat_en_r, beat_en_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [4:0]  parade_r, parade_nxt;
  logic [9:0]  step_el_r, step_el_nxt;
  logic [9:0]  beat_el_r, beat_el_nxt;

  press_t      press;
  disp_state_t disp;
  logic [9:0]  period;

  // Advance the input stage when the result register is free or being drained.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.display_word = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ms_r      <= DEBOUNCE_RST;
      beat_half_ms_r   <= BEAT_RST;
      parade_step_ms_r <= PARADE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: settle_ms_r      <= cfg_data[4:0];
        CFG_BEAT:     beat_half_ms_r   <= cfg_data;
        CFG_PARADE:   parade_step_ms_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Capture the item; payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_tick_r   <= in_ch.ms_tick;
      s1_levels_r <= in_ch.button_levels;
    end
  end

  ssd_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_adv),
    .ms_tick   (s1_tick_r),
    .levels    (s1_levels_r),
    .settle_ms (settle_ms_r),
    .press     (press)
  );

  // The word is formed from the state as it stands before this item's update.
  always_comb begin
    disp.mode         = mode_r;
    disp.pos          = pos_r;
    disp.blank_zeros  = blank_r;
    disp.beat_enable  = beat_en_r;
    disp.beat_phase   = phase_r;
    disp.count_bcd    = count_r;
    disp.parade_index = parade_r;
  end

  ssd_glyph u_glyph (
    .st   (disp),
    .word (word)
  );

  always_comb begin
    pos_nxt = pos_r + 2'd1;

    // Advance both elapsed timers, saturating.
    step_el_nxt = step_el_r;
    beat_el_nxt = beat_el_r;
    if (s1_tick_r && step_el_r != ELAPSED_MAX) step_el_nxt = step_el_r + 10'd1;
    if (s1_tick_r && beat_el_r != ELAPSED_MAX) beat_el_nxt = beat_el_r + 10'd1;

    // Button actions; mode cycles through three values, the spare code lands on parade.
    mode_nxt   = mode_r;
    parade_nxt = parade_r;
    if (press.mode) begin
      unique case (mode_r)
        MODE_COUNTER: mode_nxt = MODE_PARADE;
        MODE_PARADE:  mode_nxt = MODE_ALL_ON;
        MODE_ALL_ON:  mode_nxt = MODE_COUNTER;
        default:      mode_nxt = MODE_PARADE;
      endcase
      parade_nxt = '0;
    end
    speed_nxt = speed_r;
    if (press.speed) begin
      unique case (speed_r)
        SPEED_10MS:  speed_nxt = SPEED_100MS;
        SPEED_100MS: speed_nxt = SPEED_1MS;
        SPEED_1MS:   speed_nxt = SPEED_10MS;
        default:     speed_nxt = SPEED_100MS;
      endcase
    end
    blank_nxt   = blank_r ^ press.blank;
    beat_en_nxt = beat_en_r ^ press.beat;

    // Heartbeat toggle
    phase_nxt = phase_r;
    if (beat_el_nxt >= beat_half_ms_r) begin
      beat_el_nxt = '0;
      phase_nxt   = ~phase_r;
    end

    // Counter or parade step, judged on the mode and speed after the buttons.
    unique case (speed_nxt)
      SPEED_100MS: period = 10'd100;
      SPEED_1MS:   period = 10'd1;
      default:     period = 10'd10;
    endcase
    count_nxt = count_r;
    if (mode_nxt == MODE_COUNTER && step_el_nxt >= period) begin
      step_el_nxt = '0;
      count_nxt   = bcd_inc(count_r);
    end else if (mode_nxt == MODE_PARADE && step_el_nxt >= parade_step_ms_r) begin
      step_el_nxt = '0;
      parade_nxt  = (parade_nxt < GLYPH_LAST) ? parade_nxt + 5'd1 : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      mode_r    <= MODE_COUNTER;
      speed_r   <= SPEED_10MS;
      blank_r   <= 1'b0;
      beat_en_r <= 1'b1;
      phase_r   <= 1'b0;
      count_r   <= '0;
      parade_r  <= '0;
      step_el_r <= '0;
      beat_el_r <= '0;
    end else if (s1_adv) begin
      pos_r     <= pos_nxt;
      mode_r    <= mode_nxt;
      speed_r   <= speed_nxt;
      blank_r   <= blank_nxt;
      beat_en_r <= beat_en_nxt;
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      parade_r  <= parade_nxt;
      step_el_r <= step_el_nxt;
      beat_el_r <= beat_el_nxt;
    end
  end

  // Result register: load on advance, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_word_r <= word;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_test_pattern_mux: feeds loop passes with
// random ticks and button sequences, predicts every display word and checks it.
// Depends on ssd_pkg and the channel interfaces in ssd_if.
module testbench;
  import ssd_pkg::*;

  // Button bit positions within button_levels
  localparam int BTN_MODE  = 0;
  localparam int BTN_SPEED = 1;
  localparam int BTN_BLANK = 2;
  localparam int BTN_BEAT  = 3;

  localparam logic [BTN_COUNT-1:0] ALL_RELEASED = 4'hF;

  // Cycles to wait for a phase to drain before calling it stuck
  localparam int DRAIN_LIMIT = 20000;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  typedef struct packed {
    logic                 ms_tick;
    logic [BTN_COUNT-1:0] levels;
  } pass_item_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Channel drive registers; each has a single writer
  logic                 in_valid  = 1'b0;
  logic                 in_tick   = 1'b0;
  logic [BTN_COUNT-1:0] in_levels = ALL_RELEASED;
  logic                 out_ready = 1'b0;

  ssd_in_if  in_ch_if ();
  ssd_out_if out_ch_if ();

  assign in_ch_if.valid         = in_valid;
  assign in_ch_if.ms_tick       = in_tick;
  assign in_ch_if.button_levels = in_levels;
  assign out_ch_if.ready        = out_ready;

  seven_segment_test_pattern_mux u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch_if),
    .out_ch    (out_ch_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pass_item_t  pending_passes[$];
  logic [15:0] expected_words[$];
  int          passes_queued  = 0;
  int          mismatch_count = 0;
  logic        in_taken       = 1'b0;
  flow_t       flow           = FLOW_FREE;

  // Predictor copy of the display state and the timing registers
  logic [1:0]  shown_digit;
  logic [1:0]  display_mode;
  logic [1:0]  speed_code;
  logic        suppress_zeros;
  logic        beat_on;
  logic        beat_lit;
  logic [15:0] bcd_count;
  logic [4:0]  parade_pos;
  logic [9:0]  step_age;
  logic [9:0]  beat_age;
  logic [3:0]  btn_level_ok;
  logic [4:0]  btn_age [BTN_COUNT];
  logic [4:0]  debounce_len;
  logic [9:0]  beat_half;
  logic [9:0]  parade_len;

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  function automatic logic [15:0] glyph_segments(input logic [4:0] g);
    case (g) inside
      5'd0, 5'd11: return SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      5'd1:        return SG_B | SG_C;
      5'd2:        return SG_A | SG_B | SG_G | SG_E | SG_D;
      5'd3:        return SG_A | SG_B | SG_G | SG_C | SG_D;
      5'd4:        return SG_F | SG_G | SG_B | SG_C;
      5'd5:        return SG_A | SG_F | SG_G | SG_C | SG_D;
      5'd6:        return SG_A | SG_F | SG_G | SG_E | SG_D | SG_C;
      5'd7:        return SG_A | SG_B | SG_C;
      5'd8:        return SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G;
      5'd9:        return SG_A | SG_B | SG_C | SG_D | SG_F | SG_G;
      5'd12:       return SG_E | SG_G | SG_C;
      5'd13:       return SG_A | SG_F | SG_G | SG_E;
      5'd14:       return SG_A | SG_F | SG_G | SG_E | SG_D;
      5'd15:       return SG_E | SG_G;
      5'd16:       return SG_D;
      default:     return '0;
    endcase
  endfunction

  function automatic logic [15:0] select_bit(input logic [1:0] d);
    case (d)
      2'd0:    return SEL_0;
      2'd1:    return SEL_1;
      2'd2:    return SEL_2;
      default: return SEL_3;
    endcase
  endfunction

  // One loop pass: build the word from the state as it stands, then advance
  // the digit, the timers, the buttons, the heartbeat and the step.
  task automatic predict_display_word(input logic tick, input logic [3:0] lv,
                                      output logic [15:0] word);
    logic [4:0] g;
    logic       lead_zero;
    logic       carried;
    logic [3:0] nib;
    int         period;
    if (display_mode == MODE_ALL_ON) begin
      g = GLYPH_EIGHT;
    end else if (display_mode == MODE_PARADE) begin
      g = (parade_pos <= GLYPH_LAST) ? parade_pos : GLYPH_BLANK;
    end else begin
      g = {1'b0, bcd_count[4*(3-shown_digit) +: 4]};
      // Blank a digit while it and everything to its left are zero
      if (suppress_zeros && shown_digit != 2'd3) begin
        lead_zero = 1'b1;
        for (int i = 0; i <= shown_digit; i++)
          if (bcd_count[4*(3-i) +: 4] != 4'd0) lead_zero = 1'b0;
        if (lead_zero) g = GLYPH_BLANK;
      end
    end
    word = glyph_segments(g);
    if (display_mode == MODE_ALL_ON) word = word | SG_DP;
    else if (beat_lit && beat_on && shown_digit == 2'd0) word = word | SG_DP;
    word = (word | SEL_MASK) & ~select_bit(shown_digit);
    shown_digit = shown_digit + 2'd1;

    if (tick) begin
      if (step_age != ELAPSED_MAX) step_age = step_age + 10'd1;
      if (beat_age != ELAPSED_MAX) beat_age = beat_age + 10'd1;
      for (int i = 0; i < BTN_COUNT; i++)
        if (btn_age[i] != BTN_ELAPSED_MAX) btn_age[i] = btn_age[i] + 5'd1;
    end

    for (int i = 0; i < BTN_COUNT; i++) begin
      if (lv[i] == btn_level_ok[i]) begin
        btn_age[i] = '0;
      end else if (btn_age[i] >= debounce_len) begin
        btn_level_ok[i] = lv[i];
        btn_age[i]      = '0;
        if (!lv[i]) begin
          case (i)
            BTN_MODE: begin
              case (display_mode)
                MODE_PARADE: display_mode = MODE_ALL_ON;
                MODE_ALL_ON: display_mode = MODE_COUNTER;
                default:     display_mode = MODE_PARADE;
              endcase
              parade_pos = '0;
            end
            BTN_SPEED: begin
              case (speed_code)
                SPEED_10MS:  speed_code = SPEED_100MS;
                SPEED_100MS: speed_code = SPEED_1MS;
                SPEED_1MS:   speed_code = SPEED_10MS;
                default:     speed_code = SPEED_100MS;
              endcase
            end
            BTN_BLANK: suppress_zeros = !suppress_zeros;
            default:   beat_on = !beat_on;
          endcase
        end
      end
    end

    if (beat_age >= beat_half) begin
      beat_age = '0;
      beat_lit = !beat_lit;
    end

    case (speed_code)
      SPEED_100MS: period = 100;
      SPEED_1MS:   period = 1;
      default:     period = 10;
    endcase
    if (display_mode == MODE_COUNTER && step_age >= period) begin
      step_age = '0;
      // Decimal increment: a nibble of nine or more rolls over and carries
      carried = 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (carried) begin
          nib = bcd_count[4*k +: 4];
          if (nib < 4'd9) begin
            bcd_count[4*k +: 4] = nib + 4'd1;
            carried = 1'b0;
          end else begin
            bcd_count[4*k +: 4] = 4'd0;
          end
        end
      end
    end else if (display_mode == MODE_PARADE && step_age >= parade_len) begin
      step_age   = '0;
      parade_pos = (parade_pos < GLYPH_LAST) ? parade_pos + 5'd1 : 5'd0;
    end
  endtask

  function automatic logic pause_now(input logic applies);
    return applies && ($urandom_range(99) < ((flow == FLOW_BOTH) ? 12 : 78));
  endfunction

  // Driver: change inputs on the falling edge. Advance to the next item only
  // once the current one was taken; never drop valid under a held item.
  always @(negedge clk) begin : drive_passes
    pass_item_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_passes.size() != 0 &&
            !pause_now(flow == FLOW_SENDER_GAPS || flow == FLOW_BOTH)) begin
          nxt = pending_passes.pop_front();
          in_valid  <= 1'b1;
          in_tick   <= nxt.ms_tick;
          in_levels <= nxt.levels;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !pause_now(flow == FLOW_RECEIVER_STALLS || flow == FLOW_BOTH);
      in_taken = 1'b0;
    end
  end

  // Monitor: sample both handshakes on the rising edge. Predict on input
  // acceptance, check against the oldest prediction on output acceptance.
  always @(posedge clk) begin : check_words
    logic [15:0] want;
    if (rst_n) begin
      if (in_valid && in_ch_if.ready) begin
        predict_display_word(in_tick, in_levels, want);
        expected_words.push_back(want);
        in_taken = 1'b1;
      end
      if (out_ch_if.valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("display word %h with no pass pending",
                                    out_ch_if.display_word));
        end else begin
          want = expected_words.pop_front();
          if (out_ch_if.display_word !== want)
            report_mismatch($sformatf("display_word got %h expected %h",
                                      out_ch_if.display_word, want));
        end
      end
    end
  end

  task automatic queue_pass(input logic tick, input logic [3:0] lv);
    pending_passes.push_back({tick, lv});
    passes_queued++;
  endtask

  // Hold a button pattern until the debounce time has run out, then release
  // it the same way. Untimed passes are sprinkled in to stretch the hold.
  task automatic queue_press(input logic [3:0] mask, input int slack);
    int need;
    int ticks;
    logic [3:0] lv;
    need = debounce_len + slack;
    for (int phase = 0; phase < 2; phase++) begin
      lv    = (phase == 0) ? ~mask : ALL_RELEASED;
      ticks = 0;
      do begin
        if ($urandom_range(3) == 0) begin
          queue_pass(1'b0, lv);
        end else begin
          queue_pass(1'b1, lv);
          ticks++;
        end
      end while (ticks < need);
    end
  endtask

  // Clean presses with random content half of the time; the rest is quiet time that
  // lets the timers run, and raw bouncing levels.
  task automatic queue_session(input int count);
    int stop;
    int r;
    logic [3:0] mask;
    stop = passes_queued + count;
    while (passes_queued < stop) begin
      r = $urandom_range(99);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 35)      mask = 4'b0001 << BTN_MODE;
        else if (r < 60) mask = 4'b0001 << BTN_SPEED;
        else if (r < 78) mask = 4'b0001 << BTN_BLANK;
        else if (r < 95) mask = 4'b0001 << BTN_BEAT;
        else             mask = 4'($urandom_range(15, 1));
        queue_press(mask, $urandom_range(2));
      end else if (r < 85) begin
        repeat ($urandom_range(12, 3)) queue_pass($urandom_range(99) < 80, ALL_RELEASED);
      end else begin
        repeat ($urandom_range(6, 1))
          queue_pass(1'($urandom_range(1)), 4'($urandom_range(15)));
      end
    end
  endtask

  // Wait for the queued passes to go in and every word to come back, then
  // let the pipeline settle before anything touches the registers.
  task automatic wait_quiet();
    int n;
    n = 0;
    while ((pending_passes.size() != 0 || in_valid || expected_words.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (pending_passes.size() != 0 || in_valid) begin
      report_mismatch($sformatf("%0d passes never accepted", pending_passes.size()));
      pending_passes.delete();
    end
    if (expected_words.size() != 0) begin
      report_mismatch($sformatf("%0d display words never delivered",
                                expected_words.size()));
      expected_words.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_len = 5'(value);
      CFG_BEAT:     beat_half    = 10'(value);
      default:      parade_len   = 10'(value);
    endcase
  endtask

  task automatic set_timing(input int deb, input int beat, input int parade);
    write_register(CFG_DEBOUNCE, deb);
    write_register(CFG_BEAT, beat);
    write_register(CFG_PARADE, parade);
  endtask

  initial begin : stimulus
    // Predictor state as the block comes out of reset
    shown_digit    = 2'd0;
    display_mode   = MODE_COUNTER;
    speed_code     = SPEED_10MS;
    suppress_zeros = 1'b0;
    beat_on        = 1'b1;
    beat_lit       = 1'b0;
    bcd_count      = '0;
    parade_pos     = '0;
    step_age       = '0;
    beat_age       = '0;
    btn_level_ok   = ALL_RELEASED;
    for (int i = 0; i < BTN_COUNT; i++) btn_age[i] = '0;
    debounce_len   = DEBOUNCE_RST;
    beat_half      = BEAT_RST;
    parade_len     = PARADE_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset timing: field extremes, every button bit both ways, all four
    // digit positions; the long debounce keeps every level change pending.
    flow = FLOW_FREE;
    queue_pass(1'b0, ALL_RELEASED);
    queue_pass(1'b1, ALL_RELEASED);
    queue_pass(1'b0, 4'h0);
    queue_pass(1'b1, 4'h0);
    queue_pass(1'b1, 4'hA);
    queue_pass(1'b1, 4'h5);
    queue_pass(1'b0, ALL_RELEASED);
    queue_pass(1'b1, ALL_RELEASED);
    wait_quiet();

    // Shortest timing: one press of each kind, the mode button around the
    // full cycle of counter, parade, all-on and back, then random traffic.
    set_timing(1, 1, 1);
    queue_press(4'b0001 << BTN_BLANK, 0);
    queue_press(4'b0001 << BTN_BEAT, 0);
    queue_press(4'b0001 << BTN_SPEED, 0);
    queue_press(4'b0001 << BTN_MODE, 0);
    queue_press(4'b0001 << BTN_MODE, 0);
    queue_press(4'b0001 << BTN_MODE, 0);
    queue_session(110);
    wait_quiet();

    // Long timing, with the sender leaving gaps
    set_timing(31, 1000, 1000);
    flow = FLOW_SENDER_GAPS;
    queue_session(90);
    wait_quiet();

    // Zero timing: buttons take at once, heartbeat and parade act every pass
    set_timing(0, 0, 0);
    flow = FLOW_BOTH;
    queue_session(60);
    wait_quiet();

    // Short timing under receiver back-pressure
    set_timing(3, 7, 2);
    flow = FLOW_RECEIVER_STALLS;
    queue_session(120);
    wait_quiet();

    // Random short timing and a random flow pattern
    set_timing($urandom_range(5, 1), $urandom_range(30, 1), $urandom_range(30, 1));
    flow = flow_t'($urandom_range(3));
    queue_session(120);
    wait_quiet();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_if.sv
hw/rtl/ssd_debounce.sv
hw/rtl/ssd_glyph.sv
hw/rtl/seven_segment_test_pattern_mux.sv
verif/testbench.sv
